/* hdl/mct_pkg.sv */
package mct_pkg;
	localparam int MARKER_COUNT = 256;
	localparam logic [16:0] CONF_ONE = 17'd32768;
	localparam logic [15:0] SMALL_SIZE = 16'd16;

	localparam logic [1:0] REQ_OBS = 2'd0;
	localparam logic [1:0] REQ_DECAY = 2'd1;
	localparam logic [1:0] REQ_VISIT = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	localparam logic [1:0] ST_CAND = 2'd0;
	localparam logic [1:0] ST_TRACK = 2'd1;
	localparam logic [1:0] ST_CONF = 2'd2;
	localparam logic [1:0] ST_VISIT = 2'd3;

	localparam logic [2:0] CFG_GAIN = 3'd0;
	localparam logic [2:0] CFG_UNST = 3'd1;
	localparam logic [2:0] CFG_ABS = 3'd2;
	localparam logic [2:0] CFG_CONFIRM = 3'd3;
	localparam logic [2:0] CFG_SWAY = 3'd4;
	localparam logic [2:0] CFG_POS = 3'd5;
	localparam logic [2:0] CFG_SIZE = 3'd6;

	typedef struct packed {
		logic [15:0] gain;
		logic [15:0] unst;
		logic [15:0] absd;
		logic [15:0] confirm;
		logic [15:0] sway;
		logic [15:0] pos;
		logic [15:0] size;
	} cfg_t;

	typedef struct packed {
		logic       load;     // capture request, read entry at req id
		logic       rd_idx;   // read entry at sweep index
		logic       calc;     // stage computation of read entry
		logic       upd_obs;  // finish observation
		logic       upd_vis;  // finish mark visited
		logic       upd_dec;  // finish one sweep entry
		logic       idx_clr;
		logic       idx_inc;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       last_idx;
		logic       id_ok;
	} stat_t;

	function automatic logic [15:0] sat16(input logic [17:0] v);
		sat16 = (v > {1'b0, CONF_ONE}) ? CONF_ONE[15:0] : v[15:0];
	endfunction

	function automatic logic [1:0] classify(input logic [15:0] c, input logic [15:0] lvl);
		if (c >= lvl) classify = ST_CONF;
		else if ({c, 1'b0} >= {1'b0, lvl}) classify = ST_TRACK;
		else classify = ST_CAND;
	endfunction
endpackage

/* hdl/mct_ctrl.sv */
module mct_ctrl import mct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t st,
	output cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CALC = 3'd1;
	localparam logic [2:0] S_UPD = 3'd2;
	localparam logic [2:0] S_DRD = 3'd3;
	localparam logic [2:0] S_DCALC = 3'd4;
	localparam logic [2:0] S_DUPD = 3'd5;

	logic [2:0] state_q;
	logic out_valid_q;
	logic fin;

	// input taken when idle and no result pending
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		fin = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid && !out_valid_q;
				cmd.idx_clr = cmd.load;
			end
			S_CALC: cmd.calc = 1'b1;
			S_UPD: begin
				cmd.upd_obs = (st.req == REQ_OBS) && st.id_ok;
				cmd.upd_vis = (st.req == REQ_VISIT) && st.id_ok;
				fin = 1'b1;
			end
			S_DRD: cmd.rd_idx = 1'b1;
			S_DCALC: cmd.calc = 1'b1;
			S_DUPD: begin
				cmd.upd_dec = 1'b1;
				cmd.idx_inc = 1'b1;
				fin = st.last_idx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (fin) out_valid_q <= 1'b1;
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_CALC;
				S_CALC: state_q <= (st.req == REQ_DECAY) ? S_DRD : S_UPD;
				S_UPD: state_q <= S_IDLE;
				S_DRD: state_q <= S_DCALC;
				S_DCALC: state_q <= S_DUPD;
				S_DUPD: state_q <= st.last_idx ? S_IDLE : S_DRD;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/mct_dp.sv */
module mct_dp import mct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  cfg_t        cfg,
	input  logic [1:0]  req_type,
	input  logic [7:0]  marker_index,
	input  logic [15:0] center_x,
	input  logic [15:0] center_y,
	input  logic [15:0] marker_size,
	input  logic [15:0] sway_level,
	input  logic [31:0] time_now,
	output logic [15:0] confidence_out,
	output logic [1:0]  status_out,
	output logic        entry_found
);
	localparam int IW = $clog2(MARKER_COUNT);
	localparam int EW = 16 * 4 + 32 + 2;

	logic [MARKER_COUNT-1:0] valid_q;
	logic [EW-1:0] mem [MARKER_COUNT];
	logic [EW-1:0] rd_q;

	logic [1:0]  req_q;
	logic [IW-1:0] id_q;
	logic        id_ok_q;
	logic [15:0] cx_q, cy_q, sz_q;
	logic        swayed_q;
	logic [31:0] now_q;
	logic [IW-1:0] idx_q;
	logic        found_q;

	logic [15:0] e_cx, e_cy, e_sz, e_conf;
	logic [31:0] e_seen;
	logic [1:0]  e_st;
	assign {e_cx, e_cy, e_sz, e_seen, e_conf, e_st} = rd_q;

	// stage after read
	logic        stable_s1, skip_s1;
	logic [31:0] prod_s1;
	logic [15:0] conf_s1, gain_s1, half_s1;

	logic [IW-1:0] addr;
	assign addr = cmd.load ? marker_index[IW-1:0] : idx_q;

	// stability terms
	logic [15:0] adx, ady;
	logic [31:0] dxx, dyy;
	logic [33:0] dist2;
	logic [31:0] tol2;
	logic [15:0] dsz;
	logic [31:0] dszs, ssz;
	logic [16:0] g2, g5, g1;
	logic [33:0] q5, q10;
	always_comb begin
		adx = (cx_q > e_cx) ? cx_q - e_cx : e_cx - cx_q;
		ady = (cy_q > e_cy) ? cy_q - e_cy : e_cy - cy_q;
		dxx = adx * adx;
		dyy = ady * ady;
		dist2 = {2'b0, dxx} + {2'b0, dyy};
		tol2 = cfg.pos * cfg.pos;
		dsz = (sz_q > e_sz) ? sz_q - e_sz : e_sz - sz_q;
		dszs = {1'b0, dsz, 15'd0};
		ssz = cfg.size * e_sz;
		g2 = {1'b0, cfg.gain} + 17'd2;
		g5 = {1'b0, cfg.gain} + 17'd5;
		g1 = {1'b0, cfg.gain} + 17'd1;
		// x / 5 as x * 52429 >> 18, exact for x below 2^18
		q5 = {17'b0, g2} * 34'd52429;
		// x / 10 as (x >> 1) / 5
		q10 = {18'b0, g5[16:1]} * 34'd52429;
	end

	logic [15:0] dmul;
	assign dmul = (req_q == REQ_DECAY) ? cfg.absd : cfg.unst;

	// post-stage arithmetic
	logic [15:0] scaled, newc, decc, first_c;
	logic [1:0]  obs_st, dec_st;
	logic [32:0] rnd;
	always_comb begin
		rnd = {1'b0, prod_s1} + 33'd16384;
		scaled = sat16(rnd[32:15]);
		if (stable_s1) newc = sat16({2'b0, conf_s1} + {2'b0, gain_s1});
		else newc = sat16({2'b0, scaled} + {2'b0, half_s1});
		decc = scaled;
		first_c = sat16({2'b0, cfg.gain});
		obs_st = (e_st == ST_VISIT) ? ST_VISIT : classify(newc, cfg.confirm);
		dec_st = (decc < cfg.confirm) ? classify(decc, cfg.confirm) : e_st;
	end

	// single table write port
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	always_comb begin
		wr_en = 1'b0;
		wr_addr = id_q;
		wr_data = {cx_q, cy_q, sz_q, now_q, newc, obs_st};
		priority if (cmd.upd_obs) begin
			wr_en = 1'b1;
			if (!found_q) wr_data = {cx_q, cy_q, sz_q, now_q, first_c, ST_CAND};
		end else if (cmd.upd_vis && found_q) begin
			wr_en = 1'b1;
			wr_data = {e_cx, e_cy, e_sz, e_seen, CONF_ONE[15:0], ST_VISIT};
		end else if (cmd.upd_dec && !skip_s1) begin
			wr_en = 1'b1;
			wr_addr = idx_q;
			wr_data = {e_cx, e_cy, e_sz, e_seen, decc, dec_st};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.upd_obs) valid_q[id_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.rd_idx) rd_q <= mem[addr];
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.load) begin
			req_q <= req_type;
			id_q <= marker_index[IW-1:0];
			id_ok_q <= (32'(marker_index) < MARKER_COUNT);
			cx_q <= center_x;
			cy_q <= center_y;
			sz_q <= marker_size;
			swayed_q <= sway_level > cfg.sway;
			now_q <= time_now;
			found_q <= valid_q[marker_index[IW-1:0]];
		end
		if (cmd.calc) begin
			stable_s1 <= (e_sz <= SMALL_SIZE) || ((dist2 <= {2'b0, tol2}) && (dszs <= ssz));
			prod_s1 <= e_conf * dmul;
			conf_s1 <= e_conf;
			gain_s1 <= swayed_q ? q5[33:18] : cfg.gain;
			half_s1 <= swayed_q ? q10[33:18] : g1[16:1];
			skip_s1 <= !valid_q[idx_q] || (e_st == ST_VISIT) || (now_q <= e_seen);
		end
		if (cmd.upd_obs) begin
			if (!found_q) begin
				confidence_out <= first_c;
				status_out <= ST_CAND;
				entry_found <= 1'b0;
			end else begin
				confidence_out <= newc;
				status_out <= obs_st;
				entry_found <= 1'b1;
			end
		end else if (cmd.upd_vis && found_q) begin
			confidence_out <= CONF_ONE[15:0];
			status_out <= ST_VISIT;
			entry_found <= 1'b1;
		end else if (cmd.upd_vis || (cmd.calc && req_q != REQ_DECAY && !id_ok_q)
				|| (cmd.calc && req_q == REQ_NONE) || cmd.upd_dec) begin
			confidence_out <= '0;
			status_out <= ST_CAND;
			entry_found <= 1'b0;
		end
	end

	assign st.req = req_q;
	assign st.id_ok = id_ok_q;
	assign st.last_idx = (idx_q == IW'(MARKER_COUNT - 1));
endmodule

/* hdl/marker_confidence_table.sv */
// Observation / mark visited / ignored request: captured in S_IDLE, computed in S_CALC and
// finished in S_UPD, then the result beat is registered. Decay tick: each table entry in turn
// is read (S_DRD), scaled (S_DCALC) and written (S_DUPD). One request at a time; the next beat
// is taken in the cycle after the result beat leaves.
// Reset: arst_n clears entry valid bits, the controller and restores register defaults;
// table contents are undefined until an entry is written.
module marker_confidence_table import mct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  marker_index,
	input  logic [15:0] center_x,
	input  logic [15:0] center_y,
	input  logic [15:0] marker_size,
	input  logic [15:0] sway_level,
	input  logic [31:0] time_now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] confidence_out,
	output logic [1:0]  status_out,
	output logic        entry_found
);
	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain <= 16'd6554;
			cfg_q.unst <= 16'd22938;
			cfg_q.absd <= 16'd29491;
			cfg_q.confirm <= 16'd26214;
			cfg_q.sway <= 16'd256;
			cfg_q.pos <= 16'd320;
			cfg_q.size <= 16'd6554;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN: cfg_q.gain <= cfg_data;
				CFG_UNST: cfg_q.unst <= cfg_data;
				CFG_ABS: cfg_q.absd <= cfg_data;
				CFG_CONFIRM: cfg_q.confirm <= cfg_data;
				CFG_SWAY: cfg_q.sway <= cfg_data;
				CFG_POS: cfg_q.pos <= cfg_data;
				CFG_SIZE: cfg_q.size <= cfg_data;
				default: ;
			endcase
		end
	end

	mct_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .cmd
	);

	mct_dp u_dp (
		.clk, .arst_n, .cmd, .st, .cfg(cfg_q), .req_type, .marker_index, .center_x,
		.center_y, .marker_size, .sway_level, .time_now, .confidence_out,
		.status_out, .entry_found
	);

	// result never exceeds 1.0
	a_conf_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> confidence_out <= 16'd32768) else $error("confidence above one");
	// visited status only comes from an existing entry
	a_visit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_out == ST_VISIT && entry_found == 1'b0) |-> 1'b0)
		else $error("visited without entry");
	// a stalled result beat stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

/* verif/tb_marker_confidence_table.sv */
module tb_marker_confidence_table;
	import mct_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_COUNT = 450;
	localparam int CYCLE_LIMIT = 600000;
	// a decay tick walks the whole table, entry by entry
	localparam int DECAY_CYCLES = 2 + 3 * MARKER_COUNT;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [7:0]  marker_index;
	logic [15:0] center_x;
	logic [15:0] center_y;
	logic [15:0] marker_size;
	logic [15:0] sway_level;
	logic [31:0] time_now;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] confidence_out;
	logic [1:0]  status_out;
	logic        entry_found;

	marker_confidence_table i_dut (.*);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	typedef struct packed {
		logic [1:0]  req;
		logic [7:0]  id;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] sz;
		logic [15:0] sway;
		logic [31:0] now;
	} request_t;

	typedef struct packed {
		logic [15:0] conf;
		logic [1:0]  status;
		logic        found;
	} verdict_t;

	// directed table row; when has_exp is set the verdict is typed in and must match
	typedef struct packed {
		request_t rq;
		logic     has_exp;
		verdict_t exp;
	} row_t;

	// mirror of the block's registers and table
	logic [15:0] m_gain, m_unst, m_abs, m_confirm, m_sway, m_pos, m_size;
	logic        tbl_valid [MARKER_COUNT];
	logic [15:0] tbl_cx [MARKER_COUNT];
	logic [15:0] tbl_cy [MARKER_COUNT];
	logic [15:0] tbl_sz [MARKER_COUNT];
	logic [31:0] tbl_seen [MARKER_COUNT];
	logic [15:0] tbl_conf [MARKER_COUNT];
	logic [1:0]  tbl_status [MARKER_COUNT];

	verdict_t    pending_verdicts[$];
	int          fail_count = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          decay_ticks = 0;
	int          cycle_count = 0;
	int          hold_off = 0;     // long receiver hold-off, cycles left
	bit          burst_mode = 0;   // no idling on either side
	bit          live_ids_only = 0;

	function automatic logic [15:0] conf_saturate(input logic [33:0] v);
		return (v > 34'd32768) ? 16'd32768 : v[15:0];
	endfunction

	function automatic logic [15:0] conf_scale(input logic [15:0] c, input logic [15:0] d);
		logic [33:0] p;
		p = ({18'd0, c} * {18'd0, d} + 34'd16384) >> 15;
		return conf_saturate(p);
	endfunction

	function automatic logic [1:0] conf_grade(input logic [15:0] c);
		if ({1'b0, c} >= {1'b0, m_confirm}) return ST_CONF;
		if ({c, 1'b0} >= {1'b0, m_confirm}) return ST_TRACK;
		return ST_CAND;
	endfunction

	function automatic bit looks_steady(input int idx, input request_t rq);
		logic signed [35:0] dx, dy;
		logic [35:0] dist2, tol2;
		logic [15:0] dsz;
		if (tbl_sz[idx] <= SMALL_SIZE) return 1;
		dx = $signed({20'd0, rq.cx}) - $signed({20'd0, tbl_cx[idx]});
		dy = $signed({20'd0, rq.cy}) - $signed({20'd0, tbl_cy[idx]});
		dist2 = unsigned'(dx * dx) + unsigned'(dy * dy);
		tol2 = {20'd0, m_pos} * {20'd0, m_pos};
		dsz = (rq.sz > tbl_sz[idx]) ? rq.sz - tbl_sz[idx] : tbl_sz[idx] - rq.sz;
		return dist2 <= tol2 &&
			({16'd0, dsz} * 32'd32768) <= ({16'd0, m_size} * {16'd0, tbl_sz[idx]});
	endfunction

	// advance the mirror by one request and return the verdict it produces
	function automatic verdict_t track_marker(input request_t rq);
		verdict_t v;
		logic [15:0] g, h, c;
		bit swayed;
		v = '0;
		if (rq.req == REQ_OBS) begin
			if (!tbl_valid[rq.id]) begin
				tbl_valid[rq.id] = 1'b1;
				v.conf = conf_saturate({18'd0, m_gain});
				v.status = ST_CAND;
			end else begin
				swayed = rq.sway > m_sway;
				v.found = 1'b1;
				c = tbl_conf[rq.id];
				if (looks_steady(rq.id, rq)) begin
					g = swayed ? 16'((17'(m_gain) + 17'd2) / 17'd5) : m_gain;
					c = conf_saturate({18'd0, c} + {18'd0, g});
				end else begin
					h = swayed ? 16'((17'(m_gain) + 17'd5) / 17'd10)
						: 16'((17'(m_gain) + 17'd1) / 17'd2);
					c = conf_scale(c, m_unst);
					c = conf_saturate({18'd0, c} + {18'd0, h});
				end
				v.conf = c;
				v.status = (tbl_status[rq.id] == ST_VISIT) ? ST_VISIT : conf_grade(c);
			end
			tbl_cx[rq.id] = rq.cx;
			tbl_cy[rq.id] = rq.cy;
			tbl_sz[rq.id] = rq.sz;
			tbl_seen[rq.id] = rq.now;
			tbl_conf[rq.id] = v.conf;
			tbl_status[rq.id] = v.status;
		end else if (rq.req == REQ_DECAY) begin
			for (int i = 0; i < MARKER_COUNT; i++) begin
				if (tbl_valid[i] && tbl_status[i] != ST_VISIT && rq.now > tbl_seen[i]) begin
					tbl_conf[i] = conf_scale(tbl_conf[i], m_abs);
					if ({1'b0, tbl_conf[i]} < {1'b0, m_confirm})
						tbl_status[i] = conf_grade(tbl_conf[i]);
				end
			end
		end else if (rq.req == REQ_VISIT && tbl_valid[rq.id]) begin
			tbl_status[rq.id] = ST_VISIT;
			tbl_conf[rq.id] = 16'd32768;
			v.conf = 16'd32768;
			v.status = ST_VISIT;
			v.found = 1'b1;
		end
		return v;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_GAIN: m_gain = val;
			CFG_UNST: m_unst = val;
			CFG_ABS: m_abs = val;
			CFG_CONFIRM: m_confirm = val;
			CFG_SWAY: m_sway = val;
			CFG_POS: m_pos = val;
			default: m_size = val;
		endcase
	endtask

	task automatic load_settings(input logic [15:0] g, u, a, cl, sw, p, s);
		write_reg(CFG_GAIN, g);
		write_reg(CFG_UNST, u);
		write_reg(CFG_ABS, a);
		write_reg(CFG_CONFIRM, cl);
		write_reg(CFG_SWAY, sw);
		write_reg(CFG_POS, p);
		write_reg(CFG_SIZE, s);
	endtask

	// wait until every verdict is back, then let a possible decay sweep finish
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DECAY_CYCLES + 10) @(posedge clk);
	endtask

	// send one beat; the verdict is queued at the accepting edge
	task automatic send_request(input request_t rq, input bit has_exp, input verdict_t exp);
		verdict_t v;
		if (!burst_mode)
			while ($urandom_range(99) < 38) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		{req_type, marker_index, center_x, center_y, marker_size, sway_level, time_now} <= rq;
		do @(posedge clk); while (in_stall);
		v = track_marker(rq);
		if (has_exp && v !== exp) begin
			$display("%0t directed row disagrees: typed %h, predicted %h", $time, exp, v);
			fail_count++;
		end
		pending_verdicts.insert(pending_verdicts.size(), v);
		beats_in++;
		if (rq.req == REQ_DECAY) decay_ticks++;
	endtask

	function automatic request_t random_request(input logic [31:0] t);
		request_t rq;
		int pick;
		rq.req = REQ_OBS;
		rq.id = live_ids_only ? 8'($urandom_range(15)) : 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 3) rq.req = REQ_DECAY;
		else if (pick < 10) rq.req = REQ_VISIT;
		else if (pick < 13) rq.req = REQ_NONE;
		// mostly near the stored entry so stable and unstable paths both show up
		if (tbl_valid[rq.id] && $urandom_range(3) != 0) begin
			rq.cx = tbl_cx[rq.id] + 16'($urandom_range(700) - 350);
			rq.cy = tbl_cy[rq.id] + 16'($urandom_range(700) - 350);
			rq.sz = tbl_sz[rq.id] + 16'($urandom_range(200) - 100);
		end else begin
			rq.cx = 16'($urandom);
			rq.cy = 16'($urandom);
			rq.sz = ($urandom_range(7) == 0) ? 16'($urandom_range(20)) : 16'($urandom);
		end
		rq.sway = ($urandom_range(1) != 0) ? 16'($urandom_range(600)) : 16'($urandom);
		rq.now = ($urandom_range(9) == 0) ? $urandom : t;
		return rq;
	endfunction

	// receiver: random stalls, a long hold-off, a burst window; checks each beat
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				beats_out++;
				if (pending_verdicts.size() == 0) begin
					$display("%0t unexpected result beat conf=%h st=%h found=%b", $time,
						confidence_out, status_out, entry_found);
					fail_count++;
				end else begin
					verdict_t e;
					e = pending_verdicts.pop_front();
					if (confidence_out !== e.conf) begin
						$display("%0t confidence: expected %h, actual %h", $time, e.conf,
							confidence_out);
						fail_count++;
					end
					if (status_out !== e.status) begin
						$display("%0t status: expected %h, actual %h", $time, e.status,
							status_out);
						fail_count++;
					end
					if (entry_found !== e.found) begin
						$display("%0t entry_found: expected %b, actual %b", $time, e.found,
							entry_found);
						fail_count++;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= burst_mode ? 1'b0 : ($urandom_range(99) < 38);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		request_t rq;
		logic [31:0] t;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		{req_type, marker_index, center_x, center_y, marker_size, sway_level, time_now} = '0;
		m_gain = 16'd6554; m_unst = 16'd22938; m_abs = 16'd29491; m_confirm = 16'd26214;
		m_sway = 16'd256; m_pos = 16'd320; m_size = 16'd6554;
		foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: fields {req,id,cx,cy,sz,sway,now}, has_exp, {conf,status,found}
		rows.insert(rows.size(), '{'{REQ_VISIT, 8'd5, 16'd0, 16'd0, 16'd0, 16'd0, 32'd1},
			1'b1, '{16'd0, ST_CAND, 1'b0}});
		rows.insert(rows.size(), '{'{REQ_OBS, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0},
			1'b1, '{16'd6554, ST_CAND, 1'b0}});
		rows.insert(rows.size(), '{'{REQ_OBS, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF}, 1'b0, '0});  // tiny stored size: always stable, swayed
		rows.insert(rows.size(), '{'{REQ_OBS, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,
			32'd5}, 1'b0, '0});
		rows.insert(rows.size(), '{'{REQ_OBS, 8'd0, 16'd0, 16'd0, 16'd100, 16'd0, 32'd6},
			1'b0, '0});
		rows.insert(rows.size(), '{'{REQ_OBS, 8'd0, 16'd0, 16'd0, 16'd100, 16'd300, 32'd7},
			1'b0, '0});
		rows.insert(rows.size(), '{'{REQ_OBS, 8'd255, 16'd1000, 16'd1000, 16'd800, 16'd0,
			32'd10}, 1'b1, '{16'd6554, ST_CAND, 1'b0}});
		for (int k = 0; k < 5; k++)
			rows.insert(rows.size(), '{'{REQ_OBS, 8'd255, 16'd1000 + 16'(k), 16'd1000,
				16'd800, 16'd0, 32'd11 + k}, 1'b0, '0});
		rows.insert(rows.size(), '{'{REQ_OBS, 8'd255, 16'd5000, 16'd1000, 16'd800, 16'd0,
			32'd20}, 1'b0, '0});  // big move: unstable
		rows.insert(rows.size(), '{'{REQ_DECAY, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd30},
			1'b1, '{16'd0, ST_CAND, 1'b0}});
		rows.insert(rows.size(), '{'{REQ_VISIT, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 32'd31},
			1'b1, '{16'd32768, ST_VISIT, 1'b1}});
		rows.insert(rows.size(), '{'{REQ_OBS, 8'd255, 16'd9000, 16'd9000, 16'd9000, 16'd0,
			32'd32}, 1'b0, '0});  // visited stays visited
		rows.insert(rows.size(), '{'{REQ_DECAY, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0},
			1'b1, '{16'd0, ST_CAND, 1'b0}});
		rows.insert(rows.size(), '{'{REQ_NONE, 8'd0, 16'd1, 16'd1, 16'd1, 16'd1, 32'd40},
			1'b1, '{16'd0, ST_CAND, 1'b0}});
		rows.insert(rows.size(), '{'{REQ_DECAY, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd0,
			32'hFFFF_FFFF}, 1'b1, '{16'd0, ST_CAND, 1'b0}});
		foreach (rows[k]) begin
			r = rows[k];
			send_request(r.rq, r.has_exp, r.exp);
		end
		drain_block();

		// extremes of every register, then random phases
		load_settings(16'd32768, 16'd0, 16'd32768, 16'd1, 16'd0, 16'd0, 16'd0);
		t = 32'd100;
		for (int phase = 0; phase < 5; phase++) begin
			live_ids_only = (phase != 2);
			burst_mode = (phase == 3);
			for (int n = 0; n < ITEM_COUNT / 5; n++) begin
				t += $urandom_range(3);
				rq = random_request(t);
				// keep decay sweeps rare enough for the run length
				if (rq.req == REQ_DECAY && decay_ticks > 40) rq.req = REQ_OBS;
				if (phase == 1 && n == 10) hold_off = 300;  // block fills, input stalls
				send_request(rq, 1'b0, '0);
			end
			drain_block();
			case (phase)
				0: load_settings(16'd6554, 16'd22938, 16'd29491, 16'd26214, 16'd256,
					16'd320, 16'd6554);
				1: load_settings(16'd0, 16'd65535, 16'd0, 16'd65535, 16'd65535,
					16'd65535, 16'd65535);
				2: load_settings(16'($urandom_range(32768)), 16'($urandom_range(32768)),
					16'($urandom_range(32768)), 16'($urandom_range(1, 32768)),
					16'($urandom_range(600)), 16'($urandom_range(400)), 16'($urandom));
				3: load_settings(16'd3000, 16'd32768, 16'd16384, 16'd32768, 16'd100,
					16'd200, 16'd3000);
				default: ;
			endcase
		end
		drain_block();

		$display("Run sent %0d beats (%0d decay sweeps) and checked %0d result beats",
			beats_in, decay_ticks, beats_out);
		$display("across six register settings, including zero and full-scale values.");
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
